// ===== hw/rtl/har_pkg.sv =====
// ============================================================================
// har_pkg: shared types, constants and functions for the Hill rate unit
// Holds the payload structs, the item class codes, the queue entry and the
// constant-function builder for the exp2 root factors.
// ============================================================================
package har_pkg;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RATE_GAIN     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HALF_CONSTANT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HILL_EXPONENT = 2'd2;

    localparam logic [31:0] RATE_GAIN_RESET     = 32'h0001_0000;
    localparam logic [31:0] HALF_CONSTANT_RESET = 32'h0001_0000;
    localparam logic [15:0] HILL_EXPONENT_RESET = 16'h1000;

    // Fixed-point constants
    localparam int          FRAC_BITS = 30;
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [31:0] POW_MAX   = 32'hFFFF_FFFF;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Number of quotient bits produced by the divider
    localparam int DIV_BITS = 32;

    typedef struct packed {
        logic [23:0]        concentration;
        logic signed [31:0] accum_in;
    } item_t;

    typedef struct packed {
        logic signed [31:0] accum_out;
        logic [31:0]        rate;
        logic               undefined_flag;
        logic               saturated_flag;
    } result_t;

    // Item class decided by the front end
    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,   // full log/exp evaluation
        CLS_ZERO   = 2'd1,   // zero concentration, nonzero exponent
        CLS_ONE    = 2'd2    // zero exponent
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [4:0]  lead;   // position of the leading one of A
        logic [31:0] mant;   // A normalized so that bit 31 is set
        logic [31:0] acc;
    } entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic        valid;
        cls_t        cls;
        logic [31:0] acc;
    } side_t;

    // Integer square root, bit-pair method
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = x;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q2.30 by repeated truncated square roots of 2.0
    function automatic logic [31:0] root_q30(input int k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int j = 1; j <= FRAC_BITS; j++)
        begin
            if (j <= k)
            begin
                r = isqrt64(r << FRAC_BITS);
            end
        end
        return r[31:0];
    endfunction

endpackage

// ===== hw/rtl/har_front.sv =====
// ============================================================================
// har_front: classify and normalize incoming requests
// Sorts each item into a special or normal class and finds the leading one
// of the concentration, then pushes the prepared entry into the queue.
// ============================================================================
module har_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  har_pkg::item_t      item,
    input  logic [15:0]         hill_exponent,
    input  har_pkg::q_stat_t    q_stat,
    output logic                push,
    output har_pkg::entry_t     entry
);

    logic [4:0]  lead;
    logic [31:0] wide_a;
    logic        busy_reg;
    logic        busy_next;

    // Accept whenever the queue has room
    assign item_ready = !q_stat.full;
    assign push       = item_valid && item_ready;

    // Track whether the front has seen traffic since reset
    assign busy_next = busy_reg || push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Find the leading one of the concentration
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (item.concentration[i])
            begin
                lead = 5'(i);
            end
        end
    end

    assign wide_a = {8'd0, item.concentration};

    // Classify and build the queue entry
    always_comb
    begin
        entry.lead = lead;
        entry.mant = wide_a << (5'd31 - lead);
        entry.acc  = item.accum_in;
        if (hill_exponent == '0)
        begin
            entry.cls = har_pkg::CLS_ONE;
        end
        else if (item.concentration == '0)
        begin
            entry.cls = har_pkg::CLS_ZERO;
        end
        else
        begin
            entry.cls = har_pkg::CLS_NORMAL;
        end
    end

endmodule

// ===== hw/rtl/har_queue.sv =====
// ============================================================================
// har_queue: short request queue between front and back
// Four entries in flops with registered pointers and fill count.
// ============================================================================
module har_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  har_pkg::entry_t     push_entry,
    input  logic                pop,
    output har_pkg::entry_t     pop_entry,
    output har_pkg::q_stat_t    q_stat
);

    har_pkg::entry_t                   slot_reg [har_pkg::QDEPTH];
    logic [har_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [har_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [har_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [har_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [har_pkg::QCNT_W-1:0]        count_reg;
    logic [har_pkg::QCNT_W-1:0]        count_next;

    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == har_pkg::QCNT_W'(har_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_entry    = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/har_back.sv =====
// ============================================================================
// har_back: pipelined Hill rate evaluation
// log2 by 30 squaring stages, scale by n, exp2 by 30 root-factor stages,
// multiply, 32-stage restoring divide, saturating accumulate, output reg.
// The whole pipe advances together when the output register is free.
// ============================================================================
module har_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  har_pkg::q_stat_t    q_stat,
    input  har_pkg::entry_t     pop_entry,
    output logic                pop,
    input  logic [31:0]         rate_gain,
    input  logic [31:0]         half_constant,
    input  logic [15:0]         hill_exponent,
    output logic                result_valid,
    input  logic                result_ready,
    output har_pkg::result_t    result
);

    localparam int LN = har_pkg::FRAC_BITS;
    localparam int DN = har_pkg::DIV_BITS;

    logic adv;

    // log2 stages
    har_pkg::side_t lg_side_reg [LN+1];
    logic [31:0]    lg_m_reg    [LN+1];
    logic [29:0]    lg_frac_reg [LN+1];
    logic [4:0]     lg_lead_reg [LN+1];

    // magnitude, scaled exponent, exp2 setup
    har_pkg::side_t     lm_side_reg;
    logic               lm_neg_reg;
    logic [34:0]        lm_mag_reg;
    har_pkg::side_t     pm_side_reg;
    logic               pm_neg_reg;
    logic [8:0]         pm_ipart_reg;
    logic [29:0]        pm_f_reg;
    har_pkg::side_t     es_side_reg;
    logic signed [9:0]  es_ip_reg;
    logic [29:0]        es_f_reg;
    logic               es_sat_reg;

    // exp2 stages
    har_pkg::side_t     ex_side_reg [LN+1];
    logic [31:0]        ex_m_reg    [LN+1];
    logic [29:0]        ex_f_reg    [LN+1];
    logic signed [9:0]  ex_ip_reg   [LN+1];
    logic               ex_sat_reg  [LN+1];

    // power and multiply
    har_pkg::side_t     pw_side_reg;
    logic [31:0]        pw_reg;
    logic               pw_sat_reg;
    har_pkg::side_t     mm_side_reg;
    logic [63:0]        mm_prod_reg;
    logic [32:0]        mm_den_reg;
    logic               mm_sat_reg;

    // divide stages
    har_pkg::side_t     dv_side_reg [DN+1];
    logic [64:0]        dv_rem_reg  [DN+1];
    logic [32:0]        dv_den_reg  [DN+1];
    logic [31:0]        dv_q_reg    [DN+1];
    logic               dv_sat_reg  [DN+1];

    // output
    logic               result_valid_reg;
    har_pkg::result_t   result_reg;

    // combinational helpers
    logic signed [35:0] lv;
    logic [50:0]        nprod;
    logic signed [9:0]  ip_next;
    logic [29:0]        f_next;
    logic               sat_next;
    logic signed [10:0] shv;
    logic [10:0]        shr;
    logic [63:0]        wide_pw;
    logic [31:0]        pw_next;
    logic [31:0]        rate_fin;
    logic signed [33:0] sum;
    har_pkg::result_t   result_next;

    assign adv          = !result_valid_reg || result_ready;
    assign pop          = adv && !q_stat.empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Load the first log stage from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_side_reg[0] <= '0;
        end
        else if (adv)
        begin
            lg_side_reg[0].valid <= pop;
            lg_side_reg[0].cls   <= pop_entry.cls;
            lg_side_reg[0].acc   <= pop_entry.acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lg_m_reg[0]    <= pop_entry.mant;
            lg_frac_reg[0] <= '0;
            lg_lead_reg[0] <= pop_entry.lead;
        end
    end

    // One fraction bit of log2 per stage by squaring
    for (genvar k = 1; k <= LN; k++)
    begin : g_log
        logic [63:0] sq;
        assign sq = 64'(lg_m_reg[k-1]) * 64'(lg_m_reg[k-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lg_side_reg[k] <= '0;
            end
            else if (adv)
            begin
                lg_side_reg[k] <= lg_side_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lg_frac_reg[k] <= {lg_frac_reg[k-1][28:0], sq[63]};
                lg_m_reg[k]    <= sq[63] ? sq[63:32] : sq[62:31];
                lg_lead_reg[k] <= lg_lead_reg[k-1];
            end
        end
    end

    // Signed log2 value, then its magnitude
    assign lv = ($signed({31'd0, lg_lead_reg[LN]}) - 36'sd16) * 36'sd1073741824
              + $signed({6'd0, lg_frac_reg[LN]});

    // Scale by the exponent
    assign nprod = 51'(hill_exponent) * 51'(lm_mag_reg);

    // Split into integer and fraction for exp2
    always_comb
    begin
        sat_next = 1'b0;
        f_next   = pm_f_reg;
        if (!pm_neg_reg)
        begin
            ip_next  = $signed({1'b0, pm_ipart_reg});
            sat_next = (pm_ipart_reg >= 9'd16);
        end
        else if (pm_f_reg == '0)
        begin
            ip_next = -$signed({1'b0, pm_ipart_reg});
        end
        else
        begin
            ip_next = -$signed({1'b0, pm_ipart_reg}) - 10'sd1;
            f_next  = 30'(31'h4000_0000 - 31'(pm_f_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lm_side_reg <= '0;
            pm_side_reg <= '0;
            es_side_reg <= '0;
        end
        else if (adv)
        begin
            lm_side_reg <= lg_side_reg[LN];
            pm_side_reg <= lm_side_reg;
            es_side_reg <= pm_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lm_neg_reg   <= lv[35];
            lm_mag_reg   <= lv[35] ? 35'(-lv) : lv[34:0];
            pm_neg_reg   <= lm_neg_reg;
            pm_ipart_reg <= nprod[50:42];
            pm_f_reg     <= nprod[41:12];
            es_ip_reg    <= ip_next;
            es_f_reg     <= f_next;
            es_sat_reg   <= sat_next;
        end
    end

    // Load the first exp2 stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_side_reg[0] <= '0;
        end
        else if (adv)
        begin
            ex_side_reg[0] <= es_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_m_reg[0]   <= har_pkg::ONE_Q30;
            ex_f_reg[0]   <= es_f_reg;
            ex_ip_reg[0]  <= es_ip_reg;
            ex_sat_reg[0] <= es_sat_reg;
        end
    end

    // Multiply in one root factor per fraction bit
    for (genvar k = 1; k <= LN; k++)
    begin : g_exp
        localparam logic [31:0] ROOT = har_pkg::root_q30(k);
        logic [63:0] mp;
        assign mp = 64'(ex_m_reg[k-1]) * 64'(ROOT);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ex_side_reg[k] <= '0;
            end
            else if (adv)
            begin
                ex_side_reg[k] <= ex_side_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_m_reg[k]   <= ex_f_reg[k-1][LN-k] ? mp[61:30] : ex_m_reg[k-1];
                ex_f_reg[k]   <= ex_f_reg[k-1];
                ex_ip_reg[k]  <= ex_ip_reg[k-1];
                ex_sat_reg[k] <= ex_sat_reg[k-1];
            end
        end
    end

    // Scale the mantissa to Q16.16 and apply the special classes
    always_comb
    begin
        shv     = $signed({ex_ip_reg[LN][9], ex_ip_reg[LN]}) - 11'sd14;
        shr     = 11'(-shv);
        wide_pw = '0;
        if (!shv[10])
        begin
            wide_pw = 64'(ex_m_reg[LN]) << shv[5:0];
        end
        else if (shr <= 11'd40)
        begin
            wide_pw = (64'(ex_m_reg[LN]) + (64'd1 << (shr[5:0] - 6'd1))) >> shr[5:0];
        end
        pw_next = wide_pw[31:0];
        unique case (ex_side_reg[LN].cls)
            har_pkg::CLS_ZERO:   pw_next = '0;
            har_pkg::CLS_ONE:    pw_next = har_pkg::ONE_Q16;
            har_pkg::CLS_NORMAL:
            begin
                if (ex_sat_reg[LN])
                begin
                    pw_next = har_pkg::POW_MAX;
                end
            end
            default:             pw_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_side_reg    <= '0;
            mm_side_reg    <= '0;
            dv_side_reg[0] <= '0;
        end
        else if (adv)
        begin
            pw_side_reg    <= ex_side_reg[LN];
            mm_side_reg    <= pw_side_reg;
            dv_side_reg[0] <= mm_side_reg;
        end
    end

    // Product, denominator, rounded numerator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pw_reg        <= pw_next;
            pw_sat_reg    <= ex_sat_reg[LN] && (ex_side_reg[LN].cls == har_pkg::CLS_NORMAL);
            mm_prod_reg   <= 64'(rate_gain) * 64'(pw_reg);
            mm_den_reg    <= 33'(half_constant) + 33'(pw_reg);
            mm_sat_reg    <= pw_sat_reg;
            dv_rem_reg[0] <= 65'(mm_prod_reg) + 65'(mm_den_reg[32:1]);
            dv_den_reg[0] <= mm_den_reg;
            dv_q_reg[0]   <= '0;
            dv_sat_reg[0] <= mm_sat_reg;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= DN; k++)
    begin : g_div
        localparam int QB = DN - k;
        logic [64:0] dsh;
        logic        fits;
        assign dsh  = 65'(dv_den_reg[k-1]) << QB;
        assign fits = (dv_rem_reg[k-1] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_side_reg[k] <= '0;
            end
            else if (adv)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k] <= fits ? dv_rem_reg[k-1] - dsh : dv_rem_reg[k-1];
                dv_q_reg[k]   <= dv_q_reg[k-1] | (fits ? (32'd1 << QB) : 32'd0);
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_sat_reg[k] <= dv_sat_reg[k-1];
            end
        end
    end

    // Add the rate to the accumulator with saturation at the top
    always_comb
    begin
        result_next.undefined_flag = (dv_den_reg[DN] == '0);
        rate_fin = result_next.undefined_flag ? 32'd0 : dv_q_reg[DN];
        sum = $signed({{2{dv_side_reg[DN].acc[31]}}, dv_side_reg[DN].acc})
            + $signed({2'b00, rate_fin});
        result_next.rate = rate_fin;
        if (sum > 34'sh0_7FFF_FFFF)
        begin
            result_next.accum_out      = 32'sh7FFF_FFFF;
            result_next.saturated_flag = 1'b1;
        end
        else
        begin
            result_next.accum_out      = sum[31:0];
            result_next.saturated_flag = dv_sat_reg[DN];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= dv_side_reg[DN].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== hw/rtl/hill_activation_rate.sv =====
// ============================================================================
// hill_activation_rate: Hill activation rate with rate accumulation
// Computes gain*A^n/(K+A^n) with A^n = exp2(n*log2 A) and adds it to a
// signed accumulator, saturating, one request per cycle unless stalled.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      har_pkg::item_t
//   result    out        result_valid / result_ready  har_pkg::result_t
//   cfg       in         cfg_write (no wait)          cfg_addr, cfg_data
//
// One request per cycle sustained while result_ready holds; a request passes
// the queue, the 30 log2 squaring stages, the 30 exp2 factor stages, the
// 32 divide stages and the output register before its result is valid.
// Reset is asynchronous and active low; registers return to 1.0 (gain, K, n).
// A stalled result freezes the back pipe; the four-entry queue keeps taking
// requests until it fills.
// ============================================================================
module hill_activation_rate
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  har_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output har_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [har_pkg::REG_IDX_W-1:0]   cfg_addr,
    input  logic [31:0]                     cfg_data
);

    logic [31:0]        rate_gain_reg;
    logic [31:0]        half_constant_reg;
    logic [15:0]        hill_exponent_reg;
    logic               push;
    logic               pop;
    har_pkg::entry_t    push_entry;
    har_pkg::entry_t    pop_entry;
    har_pkg::q_stat_t   q_stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_gain_reg     <= har_pkg::RATE_GAIN_RESET;
            half_constant_reg <= har_pkg::HALF_CONSTANT_RESET;
            hill_exponent_reg <= har_pkg::HILL_EXPONENT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                har_pkg::REG_RATE_GAIN:     rate_gain_reg     <= cfg_data;
                har_pkg::REG_HALF_CONSTANT: half_constant_reg <= cfg_data;
                har_pkg::REG_HILL_EXPONENT: hill_exponent_reg <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    har_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .hill_exponent (hill_exponent_reg),
        .q_stat        (q_stat),
        .push          (push),
        .entry         (push_entry)
    );

    har_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    har_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .rate_gain     (rate_gain_reg),
        .half_constant (half_constant_reg),
        .hill_exponent (hill_exponent_reg),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

`ifndef ASSERT_OFF
    // Queue never overfills
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= har_pkg::QCNT_W'(har_pkg::QDEPTH))
        else $error("queue count beyond depth");

    // A stalled result freezes the back pipe, so the queue cannot drain
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (q_stat.count >= $past(q_stat.count)))
        else $error("queue drained while result stalled");

    // A zero denominator forces a zero rate
    a_undef_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.undefined_flag) |-> (result.rate == '0))
        else $error("undefined result with nonzero rate");
`endif

endmodule
